// File: sv/gost_primality_test_macros.svh
// Assertion macros used by the primality test RTL.
`ifndef GOST_PRIMALITY_TEST_MACROS_SVH
`define GOST_PRIMALITY_TEST_MACROS_SVH
// Clocked assertion with active-low reset disable.
`define GPT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication form of the same check.
`define GPT_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
`endif

// File: sv/gpt_pkg.sv
// Package with widths and the small-prime table for the primality test.
package gpt_pkg;
    localparam int NUM_BITS = 32;
    localparam int CNT_W = $clog2(NUM_BITS);
    localparam int NUM_PRIMES = 95;
    localparam int PIDX_W = $clog2(NUM_PRIMES + 1);
    localparam int P_W = 9;

    typedef logic [NUM_BITS-1:0] t_word;

    localparam logic [P_W-1:0] PRIMES [NUM_PRIMES] = '{
        9'd2, 9'd3, 9'd5, 9'd7, 9'd11, 9'd13, 9'd17, 9'd19, 9'd23, 9'd29,
        9'd31, 9'd37, 9'd41, 9'd43, 9'd47, 9'd53, 9'd59, 9'd61, 9'd67, 9'd71,
        9'd73, 9'd79, 9'd83, 9'd89, 9'd97, 9'd101, 9'd103, 9'd107, 9'd109, 9'd113,
        9'd127, 9'd131, 9'd137, 9'd139, 9'd149, 9'd151, 9'd157, 9'd163, 9'd167,
        9'd173, 9'd179, 9'd181, 9'd191, 9'd193, 9'd197, 9'd199, 9'd211, 9'd223,
        9'd227, 9'd229, 9'd233, 9'd239, 9'd241, 9'd251, 9'd257, 9'd263, 9'd269,
        9'd271, 9'd277, 9'd281, 9'd283, 9'd293, 9'd307, 9'd311, 9'd313, 9'd317,
        9'd331, 9'd337, 9'd347, 9'd349, 9'd353, 9'd359, 9'd367, 9'd373, 9'd379,
        9'd383, 9'd389, 9'd397, 9'd401, 9'd409, 9'd419, 9'd421, 9'd431, 9'd433,
        9'd439, 9'd443, 9'd449, 9'd457, 9'd461, 9'd463, 9'd467, 9'd479, 9'd487,
        9'd491, 9'd499
    };
endpackage

// File: sv/gost_primality_test.sv
// Primality test: trial division of n-1 and two base-2 modular exponentiations.
// Requests with n below 4 or even are answered in the cycle after start. Otherwise
// the sequencer trial-divides n-1 by the table primes (up to 95 primes plus one
// extra divide per factor found), divides n-1 by the largest factor for the
// exponent, then steps each exponent bit with a square only or a multiply and square.
// One request at a time; busy drops as o_done rises, and o_done is high for one
// cycle with o_verdict valid; the receiver cannot stall. Synchronous active-low
// reset returns the sequencer to idle with no strobe.
`include "gost_primality_test_macros.svh"
module gost_primality_test (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [31:0]            i_candidate,
    output logic                   o_done,
    output logic                   o_verdict
);
    import gpt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_TCHK, S_TDIV, S_QDIV, S_EXP, S_MULA, S_MULB
    } t_state;

    t_state r_state;
    t_word r_n, r_rest, r_q, r_e, r_exp, r_acc, r_base;
    t_word r_dq, r_dvs, r_ma, r_mb, r_mr;
    t_word r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic [PIDX_W-1:0] r_pidx;
    logic r_phase;
    logic r_done, r_prime;

    t_word w_cand, w_nm1, w_p;
    logic [2*P_W-1:0] w_pp;
    logic [NUM_BITS:0] w_dt, w_m1, w_m1r, w_m2, w_m2r;
    logic w_dbit, w_last;

    assign w_cand = i_candidate[NUM_BITS-1:0];
    assign w_nm1 = r_n - t_word'(1);
    assign w_p = (r_pidx < PIDX_W'(NUM_PRIMES)) ?
                 t_word'(PRIMES[r_pidx[PIDX_W-1:0]]) : t_word'(1);
    assign w_pp = PRIMES[r_pidx < PIDX_W'(NUM_PRIMES) ? r_pidx : '0] *
                  PRIMES[r_pidx < PIDX_W'(NUM_PRIMES) ? r_pidx : '0];
    assign w_last = (r_cnt == CNT_W'(NUM_BITS - 1));

    // Restoring divider step.
    always_comb begin
        w_dt = {r_rem, r_dq[NUM_BITS-1]};
        w_dbit = (w_dt >= {1'b0, r_dvs});
        if (w_dbit) begin
            w_dt = w_dt - {1'b0, r_dvs};
        end
    end

    // Interleaved modular multiply step, multiplier bits MSB first.
    always_comb begin
        w_m1 = {r_mr, 1'b0};
        w_m1r = (w_m1 >= {1'b0, r_n}) ? w_m1 - {1'b0, r_n} : w_m1;
        w_m2 = w_m1r + (r_ma[NUM_BITS-1] ? {1'b0, r_mb} : '0);
        w_m2r = (w_m2 >= {1'b0, r_n}) ? w_m2 - {1'b0, r_n} : w_m2;
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done <= 1'b0;
            r_prime <= 1'b0;
            r_cnt <= '0;
            r_pidx <= '0;
            r_phase <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_n <= w_cand;
                        if (w_cand <= t_word'(1) || (!w_cand[0] && w_cand != t_word'(2))) begin
                            r_done <= 1'b1;
                            r_prime <= 1'b0;
                        end else if (w_cand == t_word'(2) || w_cand == t_word'(3)) begin
                            r_done <= 1'b1;
                            r_prime <= 1'b1;
                        end else begin
                            r_rest <= w_cand - t_word'(1);
                            r_q <= t_word'(1);
                            r_pidx <= '0;
                            r_state <= S_TCHK;
                        end
                    end
                end
                S_TCHK: begin
                    r_cnt <= '0;
                    r_rem <= '0;
                    if (r_pidx == PIDX_W'(NUM_PRIMES) ||
                        t_word'(w_pp) > r_rest) begin
                        // Leftover cofactor above one becomes the largest factor.
                        r_dq <= w_nm1;
                        r_dvs <= (r_rest > t_word'(1)) ? r_rest : r_q;
                        r_state <= S_QDIV;
                    end else begin
                        r_dq <= r_rest;
                        r_dvs <= w_p;
                        r_state <= S_TDIV;
                    end
                end
                S_TDIV, S_QDIV: begin
                    r_rem <= w_dt[NUM_BITS-1:0];
                    r_dq <= {r_dq[NUM_BITS-2:0], w_dbit};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (w_last) begin
                        if (r_state == S_TDIV) begin
                            if (w_dt == '0) begin
                                r_rest <= {r_dq[NUM_BITS-2:0], w_dbit};
                                r_q <= w_p;
                            end else begin
                                r_pidx <= r_pidx + PIDX_W'(1);
                            end
                            r_state <= S_TCHK;
                        end else begin
                            r_e <= {r_dq[NUM_BITS-2:0], w_dbit};
                            r_exp <= w_nm1;
                            r_acc <= t_word'(1);
                            r_base <= t_word'(2);
                            r_phase <= 1'b0;
                            r_state <= S_EXP;
                        end
                    end
                end
                S_EXP: begin
                    r_cnt <= '0;
                    r_mr <= '0;
                    if (r_exp == '0) begin
                        if (!r_phase) begin
                            if (r_acc != t_word'(1)) begin
                                r_done <= 1'b1;
                                r_prime <= 1'b0;
                                r_state <= S_IDLE;
                            end else begin
                                r_exp <= r_e;
                                r_acc <= t_word'(1);
                                r_base <= t_word'(2);
                                r_phase <= 1'b1;
                            end
                        end else begin
                            r_done <= 1'b1;
                            r_prime <= (r_acc != t_word'(1));
                            r_state <= S_IDLE;
                        end
                    end else if (r_exp[0]) begin
                        r_ma <= r_acc;
                        r_mb <= r_base;
                        r_state <= S_MULA;
                    end else begin
                        r_ma <= r_base;
                        r_mb <= r_base;
                        r_state <= S_MULB;
                    end
                end
                S_MULA, S_MULB: begin
                    r_mr <= w_m2r[NUM_BITS-1:0];
                    r_ma <= {r_ma[NUM_BITS-2:0], 1'b0};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (w_last) begin
                        r_cnt <= '0;
                        if (r_state == S_MULA) begin
                            r_acc <= w_m2r[NUM_BITS-1:0];
                            r_ma <= r_base;
                            r_mb <= r_base;
                            r_mr <= '0;
                            r_state <= S_MULB;
                        end else begin
                            r_base <= w_m2r[NUM_BITS-1:0];
                            r_exp <= r_exp >> 1;
                            r_state <= S_EXP;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_verdict = r_prime;

    `GPT_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_done, !busy, "strobe while busy")
    `GPT_ASSERT_IMP(a_start_moves, i_clk, i_rst_n, start && !busy,
        ##1 (r_done || busy), "accepted request neither finished nor started")
    `GPT_ASSERT(a_pidx_bound, i_clk, i_rst_n, r_pidx <= PIDX_W'(NUM_PRIMES),
        "prime index past table")
    `GPT_ASSERT_IMP(a_mod_range, i_clk, i_rst_n, r_state == S_EXP,
        r_base < r_n && r_acc < r_n, "exponent operands not reduced")
endmodule
